FILE: rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with an asynchronous active-low reset disable.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that a property holds at every rising edge outside reset.
`define MGAI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition is never seen at a rising edge outside reset.
`define MGAI_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define MGAI_ASSERT(lbl, clk, rst_n, prop, msg)
`define MGAI_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: rtl/mgai_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mgai_pkg
// Shared constants and types of the marker gap tracker.
// -----------------------------------------------------------------------------
package mgai_pkg;

    localparam int MAX_MARKERS = 1024;
    localparam int POS_W       = 20;
    localparam int ADDR_W      = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;
    localparam int CNT_W       = $clog2(MAX_MARKERS + 1);

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef struct packed {
        pos_t position;
        logic first;
    } in_item_t;

    typedef struct packed {
        pos_t longest_gap;
        logic overflow;
    } out_item_t;

    // control from the sequencer to the gap tracker
    typedef struct packed {
        logic clear;
        logic sample;
    } gap_ctl_t;

endpackage

FILE: rtl/mgai_ram.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mgai_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// -----------------------------------------------------------------------------
module mgai_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/mgai_gap.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mgai_gap
// Running widest-gap tracker over an ascending stream of marker positions.
// -----------------------------------------------------------------------------
module mgai_gap (
    input  logic              clk,
    input  logic              rst_n,
    input  mgai_pkg::gap_ctl_t ctl,
    input  mgai_pkg::pos_t    value,
    input  mgai_pkg::pos_t    seg_len,
    output mgai_pkg::pos_t    gap
);
    import mgai_pkg::*;

    pos_t prev_reg, prev_next;
    pos_t best_reg, best_next;
    pos_t diff;
    pos_t tail;

    always_comb
    begin
        diff      = value - prev_reg;
        prev_next = prev_reg;
        best_next = best_reg;
        if (ctl.clear)
        begin
            prev_next = '0;
            best_next = '0;
        end
        else if (ctl.sample)
        begin
            prev_next = value;
            if (diff > best_reg)
            begin
                best_next = diff;
            end
        end
    end

    // end gap saturates at zero when the segment is shorter than the last marker
    always_comb
    begin
        tail = (seg_len > prev_reg) ? (seg_len - prev_reg) : '0;
        gap  = (tail > best_reg) ? tail : best_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            best_reg <= '0;
        end
        else
        begin
            prev_reg <= prev_next;
            best_reg <= best_next;
        end
    end

endmodule

FILE: rtl/max_gap_after_insertions.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// max_gap_after_insertions
// Sorted marker table with insertion and widest-gap report per transaction.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_item) carries one marker position
//   and a first flag; first empties the table before the insertion.
//   Output channel (out_valid / out_stall / out_item) returns one transaction
//   per input: the widest gap between 0, the markers and segment_length, and
//   an overflow flag when a new position met a full table.
//   Configuration channel (cfg_valid / cfg_ready / cfg_data) writes
//   segment_length; write it only while the block is idle.
// Timing:
//   The table sits in one RAM with a registered read. Each item streams
//   the table once to shift entries up behind the insertion point (one
//   entry a cycle), then streams it again to find the widest gap. Invalid
//   or repeated positions skip the shift write-back. One item is in work
//   at a time; in_stall is low only while idle.
// Reset and stall:
//   Reset empties the table (count only; RAM contents are left as they are)
//   and sets segment_length to 1048575. A stalled result is held in the
//   output register while the next item may already be taken in; a finished
//   item waits only if that register is still occupied.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module max_gap_after_insertions (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mgai_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output mgai_pkg::out_item_t out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  mgai_pkg::pos_t      cfg_data
);
    import mgai_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_TAIL,
        S_SCAN,
        S_FIN
    } state_t;

    localparam cnt_t CNT_MAX = CNT_W'(MAX_MARKERS);
    localparam pos_t SEG_RST = POS_W'(1048575);

    state_t    state_reg, state_next;
    cnt_t      count_reg, count_next;
    pos_t      seg_reg, seg_next;
    pos_t      pos_reg, pos_next;
    cnt_t      rd_idx_reg, rd_idx_next;
    logic      dv_reg, dv_next;
    addr_t     d_idx_reg, d_idx_next;
    logic      found_reg, found_next;
    pos_t      carry_reg, carry_next;
    logic      ovf_reg, ovf_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;

    // RAM port signals
    logic  rd_en;
    addr_t rd_addr;
    pos_t  rd_data;
    logic  wr_en;
    addr_t wr_addr;
    pos_t  wr_data;

    gap_ctl_t gap_ctl;
    pos_t     gap_val;

    logic in_acc;
    logic in_pos_ok;
    cnt_t cnt_eff;
    logic last;
    logic issue;
    logic out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign in_acc    = in_valid && !in_stall;
    assign in_pos_ok = (in_item.position != '0) && (in_item.position < seg_reg);
    assign cnt_eff   = in_item.first ? '0 : count_reg;
    assign last      = (CNT_W'(d_idx_reg) + CNT_W'(1)) == count_reg;
    assign issue     = (rd_idx_reg < count_reg);
    assign out_free  = !out_valid_reg || !out_stall;

    // Read stream: issue one address a cycle in both table passes.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = rd_idx_reg[ADDR_W-1:0];
        if ((state_reg == S_INS) || (state_reg == S_SCAN))
        begin
            rd_en = issue;
        end
    end

    // Tracker is held clear outside the scan pass and the finish state.
    always_comb
    begin
        gap_ctl.clear  = (state_reg != S_SCAN) && (state_reg != S_FIN);
        gap_ctl.sample = (state_reg == S_SCAN) && dv_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        seg_next       = seg_reg;
        pos_next       = pos_reg;
        rd_idx_next    = rd_idx_reg;
        dv_next        = 1'b0;
        d_idx_next     = d_idx_reg;
        found_next     = found_reg;
        carry_next     = carry_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        wr_en          = 1'b0;
        wr_addr        = d_idx_reg;
        wr_data        = carry_reg;

        // release the output register once the receiver takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            seg_next = cfg_data;
        end

        // advance the read stream
        if (((state_reg == S_INS) || (state_reg == S_SCAN)) && issue)
        begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
            dv_next     = 1'b1;
            d_idx_next  = rd_idx_reg[ADDR_W-1:0];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    count_next  = cnt_eff;
                    pos_next    = in_item.position;
                    rd_idx_next = '0;
                    dv_next     = 1'b0;
                    found_next  = 1'b0;
                    ovf_next    = 1'b0;
                    if (!in_pos_ok)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (cnt_eff == '0)
                    begin
                        state_next = S_TAIL;
                    end
                    else
                    begin
                        state_next = S_INS;
                    end
                end
            end

            S_INS:
            begin
                if (dv_reg)
                begin
                    if (!found_reg)
                    begin
                        if (rd_data >= pos_reg)
                        begin
                            if ((rd_data == pos_reg) || (count_reg == CNT_MAX))
                            begin
                                // drop the insertion: repeat, or no room left
                                ovf_next    = (rd_data != pos_reg);
                                state_next  = S_SCAN;
                                rd_idx_next = '0;
                                dv_next     = 1'b0;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_data    = pos_reg;
                                carry_next = rd_data;
                                found_next = 1'b1;
                                if (last)
                                begin
                                    state_next  = S_TAIL;
                                    rd_idx_next = '0;
                                    dv_next     = 1'b0;
                                end
                            end
                        end
                        else if (last)
                        begin
                            state_next  = S_TAIL;
                            rd_idx_next = '0;
                            dv_next     = 1'b0;
                        end
                    end
                    else
                    begin
                        // shift up: write the held entry, hold the one read
                        wr_en      = 1'b1;
                        wr_data    = carry_reg;
                        carry_next = rd_data;
                        if (last)
                        begin
                            state_next  = S_TAIL;
                            rd_idx_next = '0;
                            dv_next     = 1'b0;
                        end
                    end
                end
            end

            S_TAIL:
            begin
                if (count_reg == CNT_MAX)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[ADDR_W-1:0];
                    wr_data    = found_reg ? carry_reg : pos_reg;
                    count_next = count_reg + CNT_W'(1);
                end
                state_next  = S_SCAN;
                rd_idx_next = '0;
                dv_next     = 1'b0;
            end

            S_SCAN:
            begin
                if ((count_reg == '0) || (dv_reg && last))
                begin
                    state_next = S_FIN;
                    dv_next    = 1'b0;
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.longest_gap  = gap_val;
                    out_item_next.overflow     = ovf_reg;
                    state_next                 = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            seg_reg       <= SEG_RST;
            rd_idx_reg    <= '0;
            dv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            seg_reg       <= seg_next;
            rd_idx_reg    <= rd_idx_next;
            dv_reg        <= dv_next;
            found_reg     <= found_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        d_idx_reg    <= d_idx_next;
        carry_reg    <= carry_next;
        out_item_reg <= out_item_next;
    end

    mgai_ram #(
        .WIDTH (POS_W),
        .DEPTH (MAX_MARKERS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mgai_gap u_gap (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (gap_ctl),
        .value   (rd_data),
        .seg_len (seg_reg),
        .gap     (gap_val)
    );

    // Assertions
    `MGAI_NEVER(a_count_bound, clk, rst_n, count_reg > CNT_MAX, "marker count above table size")
    `MGAI_ASSERT(a_no_write_full, clk, rst_n, wr_en |-> (count_reg < CNT_MAX), "table write while full")
    `MGAI_ASSERT(a_ovf_full, clk, rst_n, ((state_reg == S_FIN) && ovf_reg) |-> (count_reg == CNT_MAX), "overflow with free room")
    `MGAI_ASSERT(a_fin_out, clk, rst_n, ((state_reg == S_FIN) && out_free) |=> out_valid_reg, "finished item not presented")

endmodule

FILE: bench/mgai_gap_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mgai_gap_checker
// Watches the marker gap tracker's channels, predicts the widest gap for each
// input transaction and compares it with the result transactions in order.
// -----------------------------------------------------------------------------
module mgai_gap_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  mgai_pkg::in_item_t  in_item,
    input  logic                out_valid,
    input  logic                out_stall,
    input  mgai_pkg::out_item_t out_item,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  mgai_pkg::pos_t      cfg_data,
    output int                  error_total,
    output int                  results_due
);
    import mgai_pkg::*;

    pos_t      marker_table [MAX_MARKERS];
    int        marker_total;
    pos_t      seg_len;
    out_item_t expected_gaps [$];
    out_item_t want;
    out_item_t predicted;

    // Insert one marker into the sorted table and return the widest gap after it.
    function automatic out_item_t place_marker(input pos_t p, input logic clear);
        out_item_t r;
        int        k;
        int        j;
        pos_t      prev;
        pos_t      best;
        logic      seen;
        r.overflow = 1'b0;
        if (clear)
            marker_total = 0;
        if (p != '0 && p < seg_len)
        begin
            k = 0;
            while (k < marker_total && marker_table[k] < p)
                k++;
            seen = (k < marker_total) && (marker_table[k] == p);
            if (!seen)
            begin
                if (marker_total >= MAX_MARKERS)
                    r.overflow = 1'b1;
                else
                begin
                    for (j = marker_total; j > k; j--)
                        marker_table[j] = marker_table[j - 1];
                    marker_table[k] = p;
                    marker_total++;
                end
            end
        end
        prev = '0;
        best = '0;
        for (j = 0; j < marker_total; j++)
        begin
            if (marker_table[j] - prev > best)
                best = marker_table[j] - prev;
            prev = marker_table[j];
        end
        // the tail gap saturates at zero when the segment was shortened
        if (seg_len > prev && seg_len - prev > best)
            best = seg_len - prev;
        r.longest_gap = best;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_total = 0;
            seg_len      = '1;
            expected_gaps.delete();
            error_total  = 0;
            results_due  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                seg_len = cfg_data;
            // retire the result before queueing a new input transaction
            if (out_valid && !out_stall)
            begin
                if (expected_gaps.size() == 0)
                begin
                    error_total++;
                    if (error_total <= 10)
                        $display("%t: unexpected result gap=%0d overflow=%0b", $realtime,
                                 out_item.longest_gap, out_item.overflow);
                end
                else
                begin
                    want = expected_gaps.pop_front();
                    if (want.longest_gap !== out_item.longest_gap
                        || want.overflow !== out_item.overflow)
                    begin
                        error_total++;
                        if (error_total <= 10)
                            $display("%t: mismatch gap exp %0d got %0d, overflow exp %0b got %0b",
                                     $realtime, want.longest_gap, out_item.longest_gap,
                                     want.overflow, out_item.overflow);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                predicted = place_marker(in_item.position, in_item.first);
                expected_gaps.insert(expected_gaps.size(), predicted);
            end
            results_due = expected_gaps.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the marker gap tracker. A directed opening covers
// the field extremes, repeated and out-of-segment positions, an empty table,
// a segment shortened under stored markers and the smallest segments; random
// insertion sequences then run under three idling regimes and several segment
// lengths. The checker beside the block predicts every result transaction.
// -----------------------------------------------------------------------------
module tb_top;
    import mgai_pkg::*;

    localparam int RESET_CYCLES = 6;
    // One transaction takes longer the more markers the table holds, so allow for
    // a full table, a long receiver hold and random stalls several times over.
    localparam int STALL_LIMIT  = 40000;
    localparam int DRAIN_CYCLES = 2100;
    localparam int HOLD_CYCLES  = 3000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;
    logic      cfg_valid;
    logic      cfg_ready;
    pos_t      cfg_data;

    int        error_total;
    int        results_due;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_request;
    int        idle_cycles;
    pos_t      cur_seg;
    pos_t      last_pos;

    max_gap_after_insertions u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    mgai_gap_checker u_gap_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .error_total (error_total),
        .results_due (results_due)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Offer one marker transaction; hold valid and payload until it is taken.
    // Valid is left high so that a following transaction needs no lowering.
    task automatic send_marker(input pos_t pos, input logic first);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= {pos, first};
        last_pos  = pos;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drain the block, then write segment_length through the config channel.
    task automatic write_segment(input pos_t len);
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_seg    = len;
    endtask

    // Mostly valid positions inside the segment, with noise, edges and repeats.
    function automatic pos_t pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return pos_t'($urandom);
        if (r < 12)
        begin
            case ($urandom_range(0, 2))
                0:       return '0;
                1:       return '1;
                default: return cur_seg;
            endcase
        end
        if (r < 20)
            return last_pos;
        if (cur_seg > 1)
            return pos_t'($urandom_range(1, cur_seg - 1));
        return pos_t'($urandom);
    endfunction

    function automatic pos_t pick_segment();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return pos_t'(1);
            2:       return pos_t'(2);
            3:       return pos_t'($urandom_range(3, 40));
            4:       return pos_t'($urandom_range(41, 5000));
            5:       return pos_t'($urandom);
            default: return '1;
        endcase
    endfunction

    // Random insertion sequences; every offered transaction counts.
    // Some sequences carry on over a segment change.
    task automatic run_random(input int target);
        int   counted;
        int   seq_len;
        logic fresh;
        logic first;
        pos_t pos;
        counted = 0;
        while (counted < target)
        begin
            if ($urandom_range(0, 3) == 0)
                write_segment(pick_segment());
            fresh   = ($urandom_range(0, 4) != 0);
            seq_len = $urandom_range(1, 12);
            for (int i = 0; i < seq_len; i++)
            begin
                first = (i == 0 && fresh) || ($urandom_range(0, 39) == 0);
                pos   = pick_position();
                send_marker(pos, first);
                counted++;
            end
        end
    endtask

    // Receiver: random stalls, or one long hold when asked for.
    initial
    begin
        int hold_len;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_len     = hold_request;
                hold_request = 0;
                out_stall   <= 1'b1;
                repeat (hold_len) @(negedge clk);
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        hold_request   = 0;
        send_idle_pct  = 7;
        recv_stall_pct = 51;
        cur_seg        = '1;
        last_pos       = pos_t'(1);
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening on the segment length left by reset.
        send_marker(pos_t'(1), 1'b1);
        send_marker(pos_t'(1048574), 1'b0);
        send_marker(pos_t'(1), 1'b0);          // already present
        send_marker('0, 1'b0);                 // at the segment start
        send_marker('1, 1'b0);                 // at the segment end
        send_marker(pos_t'(524288), 1'b0);
        send_marker('0, 1'b1);                 // cleared: empty table
        write_segment(pos_t'(1000));
        send_marker(pos_t'(500), 1'b1);
        send_marker(pos_t'(900), 1'b0);
        // shorten the segment under the stored markers
        write_segment(pos_t'(600));
        send_marker(pos_t'(100), 1'b0);
        send_marker(pos_t'(700), 1'b0);
        send_marker(pos_t'(999), 1'b0);
        write_segment(pos_t'(1));
        send_marker(pos_t'(1), 1'b1);
        send_marker('0, 1'b0);
        write_segment('0);
        send_marker(pos_t'(5), 1'b1);

        // Random sequences: sender idles lightly, receiver stalls heavily.
        run_random(92);

        // Swap the roles.
        send_idle_pct  = 51;
        recv_stall_pct = 7;
        run_random(92);

        // No idling at all; open with a long receiver hold so the block backs up.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = HOLD_CYCLES;
        run_random(91);

        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_total == 0 && results_due == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
